// File: sv/gcr_pkg.sv
// Package for the 4-to-5 group code codec: code tables, widths and mode codes.
// No dependencies; used by gcr_4b5b_group_codec.
package gcr_pkg;

    localparam int GroupBits  = 40;
    localparam int BurstCntW  = 3;

    typedef enum logic {
        MODE_DECODE = 1'b0,
        MODE_ENCODE = 1'b1
    } mode_t;

    localparam logic [7:0] BAD_CODE = 8'hFF;

    // 5-bit code -> nibble, BAD_CODE where no entry exists
    localparam logic [7:0] DEC_TAB [32] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF, 8'h08, 8'h00, 8'h01, 8'hFF, 8'h0C, 8'h04, 8'h05,
        8'hFF, 8'hFF, 8'h02, 8'h03, 8'hFF, 8'h0F, 8'h06, 8'h07,
        8'hFF, 8'h09, 8'h0A, 8'h0B, 8'hFF, 8'h0D, 8'h0E, 8'hFF
    };

    // nibble -> 5-bit code
    localparam logic [4:0] ENC_TAB [16] = '{
        5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
    };

    // byte count at which a group is complete
    localparam logic [2:0] DEC_GROUP = 3'd5;
    localparam logic [2:0] ENC_GROUP = 3'd4;

endpackage

// File: sv/gcr_4b5b_group_codec.sv
// 4-to-5 group code codec: byte stream in, byte bursts out, one mode register.
// The first result beat passes the input register and then the burst register.
// Throughput: one input beat per cycle while no results are due; a finished
// group then drains from the burst register one output beat per cycle while
// out_ready is high (five beats per four bytes encoding, four per five
// decoding). Reset (rst_n, async, active low) selects decode mode and
// clears the group, error and burst state.
module gcr_4b5b_group_codec
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       frame_last,
    // result channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       frame_end,
    output logic       code_error,
    output logic       no_data,
    // mode register write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       mode
);

    // ---------------------------------------------------------------
    // Input register: parts the input handshake from the group logic
    // ---------------------------------------------------------------
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // group state
    gcr_pkg::mode_t               mode_reg;
    logic [gcr_pkg::GroupBits-1:0] grp_shift_reg, grp_shift_next;
    logic [2:0]                    grp_cnt_reg, grp_cnt_next;
    logic                          err_hold_reg, err_hold_next;

    // burst register: up to five bytes, high byte goes out first
    logic [gcr_pkg::GroupBits-1:0] burst_reg, burst_next;
    logic [gcr_pkg::BurstCntW-1:0] burst_cnt_reg, burst_cnt_next;
    logic burst_err_reg, burst_err_next;
    logic burst_nod_reg, burst_nod_next;
    logic burst_fend_reg, burst_fend_next;

    // ---------------------------------------------------------------
    // Group logic on the registered beat
    // ---------------------------------------------------------------
    logic [gcr_pkg::GroupBits-1:0] shifted;
    logic [2:0]                    cnt_inc;
    logic                          dec_fire, enc_fire;
    logic                          dec_bad;
    logic [31:0]                   dec_word;
    logic [gcr_pkg::GroupBits-1:0] enc_word;
    logic [gcr_pkg::BurstCntW-1:0] res_cnt;
    logic [gcr_pkg::GroupBits-1:0] res_data;
    logic                          res_err, res_nod;
    logic                          burst_free, consume, out_fire, cfg_fire;

    always_comb
    begin
        logic [7:0] nib;
        logic [4:0] code;
        logic [7:0] d;

        shifted  = {grp_shift_reg[gcr_pkg::GroupBits-9:0], in_byte_reg};
        cnt_inc  = grp_cnt_reg + 3'd1;
        dec_fire = !err_hold_reg && (mode_reg == gcr_pkg::MODE_DECODE)
                   && (cnt_inc >= gcr_pkg::DEC_GROUP);
        enc_fire = !err_hold_reg && (mode_reg == gcr_pkg::MODE_ENCODE)
                   && (cnt_inc >= gcr_pkg::ENC_GROUP);

        // decode: eight 5-bit codes, most significant first
        dec_bad  = 1'b0;
        dec_word = '0;
        for (int i = 0; i < 8; i++)
        begin
            code = shifted[gcr_pkg::GroupBits-1-5*i -: 5];
            nib  = gcr_pkg::DEC_TAB[code];
            if (nib == gcr_pkg::BAD_CODE)
                dec_bad = 1'b1;
            dec_word[31-4*i -: 4] = nib[3:0];
        end

        // encode: low four bytes, high nibble first
        enc_word = '0;
        for (int j = 0; j < 4; j++)
        begin
            d = shifted[31-8*j -: 8];
            enc_word[gcr_pkg::GroupBits-1-10*j -: 5] = gcr_pkg::ENC_TAB[d[7:4]];
            enc_word[gcr_pkg::GroupBits-6-10*j -: 5] = gcr_pkg::ENC_TAB[d[3:0]];
        end
    end

    // result burst of the registered beat
    always_comb
    begin
        res_cnt  = '0;
        res_data = '0;
        res_err  = 1'b0;
        res_nod  = 1'b0;
        priority if (dec_fire && dec_bad)
        begin
            res_cnt = 3'd1;
            res_err = 1'b1;
            res_nod = 1'b1;
        end
        else if (dec_fire)
        begin
            res_cnt  = 3'd4;
            res_data = {dec_word, 8'h00};
        end
        else if (enc_fire)
        begin
            res_cnt  = 3'd5;
            res_data = enc_word;
        end
        else if (in_last_reg)
        begin
            // empty frame end: one marker beat
            res_cnt = 3'd1;
            res_nod = 1'b1;
        end
    end

    assign out_fire   = out_valid && out_ready;
    assign burst_free = (burst_cnt_reg == '0) || (burst_cnt_reg == 3'd1 && out_fire);
    // a beat with no results passes even while a burst drains
    assign consume    = in_vld_reg && (burst_free || res_cnt == '0);
    assign in_ready   = !in_vld_reg || consume;
    assign cfg_ready  = !in_vld_reg && (burst_cnt_reg == '0);
    assign cfg_fire   = cfg_valid && cfg_ready;

    // next group state
    always_comb
    begin
        grp_shift_next = grp_shift_reg;
        grp_cnt_next   = grp_cnt_reg;
        err_hold_next  = err_hold_reg;
        priority if (cfg_fire)
        begin
            grp_shift_next = '0;
            grp_cnt_next   = '0;
            err_hold_next  = 1'b0;
        end
        else if (consume)
        begin
            priority if (in_last_reg)
            begin
                grp_shift_next = '0;
                grp_cnt_next   = '0;
                err_hold_next  = 1'b0;
            end
            else if (dec_fire || enc_fire)
            begin
                grp_shift_next = '0;
                grp_cnt_next   = '0;
                err_hold_next  = dec_fire && dec_bad;
            end
            else if (!err_hold_reg)
            begin
                grp_shift_next = shifted;
                grp_cnt_next   = cnt_inc;
            end
        end
    end

    // next burst state
    always_comb
    begin
        burst_next      = burst_reg;
        burst_cnt_next  = burst_cnt_reg;
        burst_err_next  = burst_err_reg;
        burst_nod_next  = burst_nod_reg;
        burst_fend_next = burst_fend_reg;
        if (out_fire)
        begin
            burst_next     = {burst_reg[gcr_pkg::GroupBits-9:0], 8'h00};
            burst_cnt_next = burst_cnt_reg - 3'd1;
        end
        if (consume && res_cnt != '0)
        begin
            burst_next      = res_data;
            burst_cnt_next  = res_cnt;
            burst_err_next  = res_err;
            burst_nod_next  = res_nod;
            burst_fend_next = in_last_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            mode_reg       <= gcr_pkg::MODE_DECODE;
            grp_shift_reg  <= '0;
            grp_cnt_reg    <= '0;
            err_hold_reg   <= 1'b0;
            burst_cnt_reg  <= '0;
            burst_err_reg  <= 1'b0;
            burst_nod_reg  <= 1'b0;
            burst_fend_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (cfg_fire)
                mode_reg <= gcr_pkg::mode_t'(mode);
            grp_shift_reg  <= grp_shift_next;
            grp_cnt_reg    <= grp_cnt_next;
            err_hold_reg   <= err_hold_next;
            burst_cnt_reg  <= burst_cnt_next;
            burst_err_reg  <= burst_err_next;
            burst_nod_reg  <= burst_nod_next;
            burst_fend_reg <= burst_fend_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= frame_last;
        end
        burst_reg <= burst_next;
    end

    // result channel straight from the burst register
    assign out_valid  = (burst_cnt_reg != '0);
    assign out_byte   = burst_reg[gcr_pkg::GroupBits-1 -: 8];
    assign run_last   = (burst_cnt_reg == 3'd1);
    assign frame_end  = burst_fend_reg && (burst_cnt_reg == 3'd1);
    assign code_error = burst_err_reg;
    assign no_data    = burst_nod_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code_error |-> no_data && run_last && out_byte == 8'h00)
        else $error("error report is not a single empty beat");

    a_nod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && no_data |-> out_byte == 8'h00 && run_last)
        else $error("no_data beat carries a byte or is not last");

    a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        err_hold_reg |-> grp_cnt_reg == '0)
        else $error("bytes gathered while dropping after an error");

    a_burst_len: assert property (@(posedge clk) disable iff (!rst_n)
        burst_cnt_reg <= 3'd5)
        else $error("burst longer than five beats");

endmodule
